>>> sv/matrix_vector_transform_4x4_top_defines.svh
// assertion macros used by the transform engine back end
// expects clk and rst_n in the scope of each use
`ifndef MATRIX_VECTOR_TRANSFORM_4X4_TOP_DEFINES_SVH
`define MATRIX_VECTOR_TRANSFORM_4X4_TOP_DEFINES_SVH

// same-cycle implication
`define MVT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MVT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/mvt_pkg.sv
// types and constants for the 4x4 matrix-vector transform engine
// no dependencies
package mvt_pkg;

    localparam int DATA_W      = 32;
    localparam int LANES       = 4;
    localparam int DIM         = 4;
    localparam int FRAC_BITS   = 16;
    localparam int STORE_DEPTH = 16;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int PROD_W      = 2 * DATA_W;
    localparam int SUM_W       = PROD_W + 3;

    localparam int CQ_DEPTH  = 2;
    localparam int CQ_PTR_W  = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W  = $clog2(CQ_DEPTH + 1);
    localparam int OQ_DEPTH  = 8;
    localparam int OQ_PTR_W  = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W  = $clog2(OQ_DEPTH + 1);

    typedef logic signed [DATA_W-1:0] word_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    localparam sum_t RND_CONST = sum_t'(1) <<< (FRAC_BITS - 1);

    typedef enum logic
    {
        OP_LOAD  = 1'b0,
        OP_XFORM = 1'b1
    } op_t;

    typedef struct packed
    {
        op_t                     op;
        logic [IDX_W-1:0]        idx;
        word_t                   val;
        logic [LANES-1:0][DATA_W-1:0] vec;
    } cmd_t;

    typedef struct packed
    {
        logic [LANES-1:0][DATA_W-1:0] row;
        logic                         sat;
    } res_t;

endpackage

>>> sv/mvt_front.sv
// front end: accepts beats, classifies load vs transform, queues commands
// depends on mvt_pkg
module mvt_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic                       op,
    input  logic [mvt_pkg::IDX_W-1:0]  element_index,
    input  mvt_pkg::word_t             element_value,
    input  mvt_pkg::word_t             vec_x,
    input  mvt_pkg::word_t             vec_y,
    input  mvt_pkg::word_t             vec_z,
    input  mvt_pkg::word_t             vec_w,
    output logic                       cq_valid,
    output mvt_pkg::cmd_t              cq_cmd,
    input  logic                       cq_take
);
    import mvt_pkg::*;

    cmd_t                cq_mem_reg [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CQ_CNT_W-1:0] cnt_reg, cnt_next;
    logic                push_ok;
    logic                take_ok;
    cmd_t                cmd_in;

    always_comb
    begin
        cmd_in = '0;
        cmd_in.op = op_t'(op);
        if (op_t'(op) == OP_LOAD)
        begin
            cmd_in.idx = element_index;
            cmd_in.val = element_value;
        end
        else
        begin
            cmd_in.vec[0] = vec_x;
            cmd_in.vec[1] = vec_y;
            cmd_in.vec[2] = vec_z;
            cmd_in.vec[3] = vec_w;
        end
    end

    assign full     = (cnt_reg == CQ_CNT_W'(CQ_DEPTH));
    assign cq_valid = (cnt_reg != '0);
    assign cq_cmd   = cq_mem_reg[rd_ptr_reg];
    assign push_ok  = push && !full;
    assign take_ok  = cq_take && cq_valid;

    always_comb
    begin
        wr_ptr_next = push_ok ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = take_ok ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + CQ_CNT_W'(push_ok) - CQ_CNT_W'(take_ok);
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            cq_mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

>>> sv/mvt_back.sv
// back end: matrix store, product array, adder tree, rounding and clamping
// depends on mvt_pkg and the shared assertion macros
`include "matrix_vector_transform_4x4_top_defines.svh"

module mvt_back
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cq_valid,
    input  mvt_pkg::cmd_t                cq_cmd,
    output logic                         cq_take,
    input  logic [mvt_pkg::OQ_CNT_W-1:0] out_count,
    output logic                         res_valid,
    output mvt_pkg::res_t                res
);
    import mvt_pkg::*;

    localparam int OCC_W = OQ_CNT_W + 1;
    localparam sum_t W_MAX = {{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam sum_t W_MIN = {{(SUM_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

    word_t             matrix_reg [STORE_DEPTH];
    prod_t             prod_reg   [LANES][LANES];
    prod_t             prod_next  [LANES][LANES];
    sum_t              pair_reg   [LANES][2];
    sum_t              pair_next  [LANES][2];
    sum_t              tot_reg    [LANES];
    sum_t              tot_next   [LANES];
    logic              s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [OCC_W-1:0]  occ;
    logic              credit_ok;
    logic              deq;
    logic              is_load;
    sum_t              shifted;

    assign occ = OCC_W'(out_count) + OCC_W'(s1_valid_reg) + OCC_W'(s2_valid_reg)
               + OCC_W'(s3_valid_reg);
    assign credit_ok = (occ < OCC_W'(OQ_DEPTH));
    assign is_load   = (cq_cmd.op == OP_LOAD);
    assign deq       = cq_valid && (is_load || credit_ok);
    assign cq_take   = deq;

    // row r, column c uses matrix element c*DIM+r
    always_comb
    begin
        for (int r = 0; r < LANES; r++)
        begin
            for (int c = 0; c < LANES; c++)
            begin
                if (r < DIM && c < DIM)
                begin
                    prod_next[r][c] = PROD_W'(matrix_reg[IDX_W'(c*DIM + r)]
                                    * $signed(cq_cmd.vec[c]));
                end
                else
                begin
                    prod_next[r][c] = '0;
                end
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < LANES; r++)
        begin
            pair_next[r][0] = SUM_W'(prod_reg[r][0]) + SUM_W'(prod_reg[r][1]);
            pair_next[r][1] = SUM_W'(prod_reg[r][2]) + SUM_W'(prod_reg[r][3]);
            tot_next[r]     = pair_reg[r][0] + pair_reg[r][1] + RND_CONST;
        end
    end

    always_comb
    begin
        shifted = '0;
        res = '0;
        for (int r = 0; r < LANES; r++)
        begin
            shifted = tot_reg[r] >>> FRAC_BITS;
            if (r >= DIM)
            begin
                res.row[r] = '0;
            end
            else if (shifted > W_MAX)
            begin
                res.row[r] = W_MAX[DATA_W-1:0];
                res.sat    = 1'b1;
            end
            else if (shifted < W_MIN)
            begin
                res.row[r] = W_MIN[DATA_W-1:0];
                res.sat    = 1'b1;
            end
            else
            begin
                res.row[r] = shifted[DATA_W-1:0];
            end
        end
    end

    assign res_valid = s3_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                matrix_reg[i] <= '0;
            end
        end
        else if (deq && is_load)
        begin
            matrix_reg[cq_cmd.idx] <= cq_cmd.val;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        pair_reg <= pair_next;
        tot_reg  <= tot_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= deq && !is_load;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    `MVT_ASSERT_SAME(a_credit, 1'b1, occ <= OCC_W'(OQ_DEPTH), "result queue over-committed")
    `MVT_ASSERT_NEXT(a_xform_enters, deq && !is_load, s1_valid_reg, "transform lost at entry")
    `MVT_ASSERT_NEXT(a_load_silent, deq && is_load, !s1_valid_reg, "load started a result")
    `MVT_ASSERT_NEXT(a_load_write, deq && is_load,
        matrix_reg[$past(cq_cmd.idx)] == $past(cq_cmd.val), "matrix write missed")

endmodule

>>> sv/mvt_outq.sv
// result queue presenting empty/pop toward the consumer
// depends on mvt_pkg
module mvt_outq
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr,
    input  mvt_pkg::res_t                din,
    input  logic                         pop,
    output logic                         empty,
    output mvt_pkg::res_t                dout,
    output logic [mvt_pkg::OQ_CNT_W-1:0] count
);
    import mvt_pkg::*;

    res_t                mem_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OQ_CNT_W-1:0] cnt_reg, cnt_next;
    logic                rd_ok;

    assign empty = (cnt_reg == '0);
    assign dout  = mem_reg[rd_ptr_reg];
    assign count = cnt_reg;
    assign rd_ok = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = rd_ok ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + OQ_CNT_W'(wr) - OQ_CNT_W'(rd_ok);
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

>>> sv/matrix_vector_transform_4x4_top.sv
// an accepted transform beat passes the command queue, prod_reg, pair_reg, tot_reg and the result queue
// throughput: one beat per cycle, loads and transforms alike, while full is low and, for transforms,
// while the result queue has credit; 16 parallel 32x32 multipliers; a load takes effect for every
// transform accepted after it; reset clears the matrix to zero and empties both queues
// top level of the 4x4 matrix-vector transform engine
// depends on mvt_pkg, mvt_front, mvt_back, mvt_outq
module matrix_vector_transform_4x4_top
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic                       op,
    input  logic [mvt_pkg::IDX_W-1:0]  element_index,
    input  mvt_pkg::word_t             element_value,
    input  mvt_pkg::word_t             vec_x,
    input  mvt_pkg::word_t             vec_y,
    input  mvt_pkg::word_t             vec_z,
    input  mvt_pkg::word_t             vec_w,
    output logic                       empty,
    input  logic                       pop,
    output mvt_pkg::word_t             out_x,
    output mvt_pkg::word_t             out_y,
    output mvt_pkg::word_t             out_z,
    output mvt_pkg::word_t             out_w,
    output logic                       saturated
);
    import mvt_pkg::*;

    logic                cq_valid;
    cmd_t                cq_cmd;
    logic                cq_take;
    logic [OQ_CNT_W-1:0] out_count;
    logic                res_valid;
    res_t                res;
    res_t                head;

    mvt_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .op            (op),
        .element_index (element_index),
        .element_value (element_value),
        .vec_x         (vec_x),
        .vec_y         (vec_y),
        .vec_z         (vec_z),
        .vec_w         (vec_w),
        .cq_valid      (cq_valid),
        .cq_cmd        (cq_cmd),
        .cq_take       (cq_take)
    );

    mvt_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cq_valid  (cq_valid),
        .cq_cmd    (cq_cmd),
        .cq_take   (cq_take),
        .out_count (out_count),
        .res_valid (res_valid),
        .res       (res)
    );

    mvt_outq u_outq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (res_valid),
        .din   (res),
        .pop   (pop),
        .empty (empty),
        .dout  (head),
        .count (out_count)
    );

    assign out_x     = head.row[0];
    assign out_y     = head.row[1];
    assign out_z     = head.row[2];
    assign out_w     = head.row[3];
    assign saturated = head.sat;

endmodule

>>> verif/tb.sv
// self-checking testbench for matrix_vector_transform_4x4_top
// directed stimulus table, then random load/transform beats, checked against a Q16.16 predictor
// depends on mvt_pkg and the engine RTL
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import mvt_pkg::*;

    localparam int    RANDOM_BEATS = 1530;
    localparam int    QUIET_TAIL   = 150;
    localparam int    STALL_LIMIT  = 1000;
    localparam word_t MAXW         = 32'sh7FFF_FFFF;
    localparam word_t MINW         = 32'sh8000_0000;
    localparam word_t ONE          = 32'sh0001_0000;

    typedef struct
    {
        word_t row [LANES];
        logic  sat;
    } vertex_out_t;

    typedef struct
    {
        op_t              op;
        logic [IDX_W-1:0] idx;
        word_t            val;
        word_t            vec [LANES];
        bit               has_exp;
        vertex_out_t      exp;
    } stim_row_t;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  push = 1'b0;
    logic  full;
    logic  op = OP_LOAD;
    logic  [IDX_W-1:0] element_index = '0;
    word_t element_value = '0;
    word_t vec_x = '0;
    word_t vec_y = '0;
    word_t vec_z = '0;
    word_t vec_w = '0;
    logic  empty;
    logic  pop = 1'b0;
    word_t out_x;
    word_t out_y;
    word_t out_z;
    word_t out_w;
    logic  saturated;

    word_t       mat_coeff [STORE_DEPTH];
    vertex_out_t pending_out [$];
    stim_row_t   directed [$];
    int          errors = 0;
    int          beats_in = 0;
    int          loads_in = 0;
    int          results_seen = 0;
    int          sat_seen = 0;
    int          stall_left = 0;
    int          idle_cycles = 0;
    bit          quiet = 1'b0;

    matrix_vector_transform_4x4_top uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .op            (op),
        .element_index (element_index),
        .element_value (element_value),
        .vec_x         (vec_x),
        .vec_y         (vec_y),
        .vec_z         (vec_z),
        .vec_w         (vec_w),
        .empty         (empty),
        .pop           (pop),
        .out_x         (out_x),
        .out_y         (out_y),
        .out_z         (out_z),
        .out_w         (out_w),
        .saturated     (saturated)
    );

    always #10 clk = ~clk;

    function automatic vertex_out_t transform_vertex(word_t v [LANES]);
        vertex_out_t      o;
        logic signed [67:0] acc;
        o.sat = 1'b0;
        for (int r = 0; r < LANES; r++)
        begin
            acc = '0;
            for (int c = 0; c < LANES; c++)
                acc = acc + (mat_coeff[c * LANES + r] * v[c]);
            acc = (acc + 68'sd32768) >>> FRAC_BITS;
            if (acc > 68'sd2147483647)
            begin
                acc   = 68'sd2147483647;
                o.sat = 1'b1;
            end
            else if (acc < -68'sd2147483648)
            begin
                acc   = -68'sd2147483648;
                o.sat = 1'b1;
            end
            o.row[r] = acc[31:0];
        end
        return o;
    endfunction

    function automatic word_t rand_word();
        word_t mag;
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7:
            begin
                mag = $urandom_range(0, 32'h0004_0000);
                return $urandom_range(0, 1) ? -mag : mag;
            end
            8, 9, 10, 11, 12, 13, 14:
                return $urandom;
            default:
            begin
                case ($urandom_range(0, 5))
                    0: return MAXW;
                    1: return MINW;
                    2: return '0;
                    3: return 32'sd1;
                    4: return -32'sd1;
                    default: return ONE;
                endcase
            end
        endcase
    endfunction

    function automatic stim_row_t ld(logic [IDX_W-1:0] idx, word_t val);
        stim_row_t s;
        s.op      = OP_LOAD;
        s.idx     = idx;
        s.val     = val;
        s.has_exp = 1'b0;
        for (int i = 0; i < LANES; i++)
            s.vec[i] = $urandom;
        return s;
    endfunction

    function automatic stim_row_t xf(word_t x, word_t y, word_t z, word_t w);
        stim_row_t s;
        s.op      = OP_XFORM;
        s.idx     = IDX_W'($urandom);
        s.val     = $urandom;
        s.vec[0]  = x;
        s.vec[1]  = y;
        s.vec[2]  = z;
        s.vec[3]  = w;
        s.has_exp = 1'b0;
        return s;
    endfunction

    function automatic stim_row_t with_rows(stim_row_t s, word_t a, word_t b, word_t c,
                                            word_t d, logic sat);
        s.has_exp    = 1'b1;
        s.exp.row[0] = a;
        s.exp.row[1] = b;
        s.exp.row[2] = c;
        s.exp.row[3] = d;
        s.exp.sat    = sat;
        return s;
    endfunction

    task automatic drive_beat(stim_row_t s);
        push          <= 1'b1;
        op            <= s.op;
        element_index <= s.idx;
        element_value <= s.val;
        vec_x         <= s.vec[0];
        vec_y         <= s.vec[1];
        vec_z         <= s.vec[2];
        vec_w         <= s.vec[3];
        @(posedge clk);
        while (full)
            @(posedge clk);
        beats_in++;
        if (s.op == OP_LOAD)
        begin
            mat_coeff[s.idx] = s.val;
            loads_in++;
        end
        else if (s.has_exp)
            pending_out.push_back(s.exp);
        else
            pending_out.push_back(transform_vertex(s.vec));
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic check_word(string tag, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, tag, want, got);
        end
    endtask

    // result side: compare each popped beat and stall pop in bursts
    always @(posedge clk)
    begin
        vertex_out_t want;
        if (pop && !empty)
        begin
            if (pending_out.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with nothing expected, got %h %h %h %h %b",
                         $time, out_x, out_y, out_z, out_w, saturated);
            end
            else
            begin
                want = pending_out.pop_front();
                results_seen++;
                if (want.sat)
                    sat_seen++;
                check_word("out_x", want.row[0], out_x);
                check_word("out_y", want.row[1], out_y);
                check_word("out_z", want.row[2], out_z);
                check_word("out_w", want.row[3], out_w);
                check_word("saturated", 32'(want.sat), 32'(saturated));
            end
        end
        if (quiet)
            pop <= 1'b1;
        else if (stall_left > 0)
        begin
            pop <= 1'b0;
            stall_left--;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            pop <= 1'b0;
            stall_left = $urandom_range(0, 2);
        end
        else
            pop <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        stim_row_t s;
        int        drain;
        for (int i = 0; i < STORE_DEPTH; i++)
            mat_coeff[i] = '0;

        directed.push_back(with_rows(xf(MAXW, MAXW, MAXW, MAXW), 0, 0, 0, 0, 1'b0));
        directed.push_back(with_rows(xf(MINW, MINW, MINW, MINW), 0, 0, 0, 0, 1'b0));
        directed.push_back(ld(0, MAXW));
        directed.push_back(with_rows(xf(MAXW, 0, 0, 0), MAXW, 0, 0, 0, 1'b1));
        directed.push_back(with_rows(xf(MINW, 0, 0, 0), MINW, 0, 0, 0, 1'b1));
        directed.push_back(ld(0, ONE));
        directed.push_back(ld(5, ONE));
        directed.push_back(ld(10, ONE));
        directed.push_back(ld(15, ONE));
        directed.push_back(with_rows(xf(ONE, 32'sh0002_0000, -32'sh0003_0000, 32'sh0004_0000),
                                     ONE, 32'sh0002_0000, -32'sh0003_0000, 32'sh0004_0000,
                                     1'b0));
        directed.push_back(with_rows(xf(MAXW, MINW, 0, -1), MAXW, MINW, 0, -1, 1'b0));
        directed.push_back(ld(15, MINW));
        directed.push_back(xf(0, 0, 0, MINW));
        // half-lsb ties round up
        directed.push_back(ld(0, 32'sh0000_8000));
        directed.push_back(xf(1, 0, 0, 0));
        directed.push_back(xf(-1, 0, 0, 0));
        directed.push_back(xf(3, 0, 0, 0));
        directed.push_back(ld(1, -ONE));
        directed.push_back(ld(6, MAXW));
        directed.push_back(ld(9, MINW));
        directed.push_back(ld(12, 32'sh0001_8000));
        directed.push_back(xf(MAXW, MINW, MAXW, MINW));
        directed.push_back(xf(ONE, -ONE, 32'sh0000_0001, 32'sh7FFF_0000));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            drive_beat(directed[i]);

        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n >= RANDOM_BEATS - QUIET_TAIL)
                quiet = 1'b1;
            if ($urandom_range(0, 99) < 35)
                s = ld(IDX_W'($urandom_range(0, STORE_DEPTH - 1)), rand_word());
            else
                s = xf(rand_word(), rand_word(), rand_word(), rand_word());
            drive_beat(s);
        end
        push <= 1'b0;

        while (pending_out.size() != 0)
            @(posedge clk);
        drain = 0;
        while (drain < 12)
        begin
            @(posedge clk);
            drain++;
        end

        $display("run covered %0d beats in (%0d loads), %0d transform results checked",
                 beats_in, loads_in, results_seen);
        $display("%0d results expected saturated, %0d mismatches", sat_seen, errors);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
